/* sv/mwf_pkg.sv */
package mwf_pkg;

	// Field widths fixed by the stream format
	localparam int CMD_W    = 2;
	localparam int REQ_W    = 8;
	localparam int STATUS_W = 3;
	localparam int TID_W    = 8;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 24;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_WAITERS    = 16;
	localparam int DEF_THREAD_ID_BITS = 8;

	// Request commands
	localparam logic [CMD_W-1:0] CMD_LOCK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TRY_LOCK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNLOCK   = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_OWNER  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_HANDED_OFF = 3'd5;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd6;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_req;   // capture the incoming request
		logic exec;       // apply the request and load the result register
	} ctl_t;

endpackage

/* sv/mutex_with_fifo_waiters_top.sv */
// Hardware mutex with a FIFO of waiting threads. Each input item carries a
// command (lock, try lock, unlock) and the requesting thread's id, and each
// one yields exactly one result item: a status code, the id of a waiter that
// was handed the mutex (if any), and the owner after the request. Unlock by
// the owner hands the mutex directly to the oldest waiter, if there is one.
// An accepted item passes through the queue read step, then the execute
// step, which loads the result register; the queue memory's registered read
// of the oldest waiter is why the read step is needed. The block takes one
// item at a time and is back in its idle state, ready to accept the next,
// once the result is loaded. A loaded result waits in its own register, so a
// stalled result side delays only the execute step of the next item.
// The waiter queue needs no clearing after reset.
module mutex_with_fifo_waiters_top #(
	parameter int MAX_WAITERS    = mwf_pkg::DEF_MAX_WAITERS,
	parameter int THREAD_ID_BITS = mwf_pkg::DEF_THREAD_ID_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// requests
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mwf_pkg::S_DATA_W-1:0]  s_tdata,  // cmd[1:0], requester[9:2], zero pad
	// results
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mwf_pkg::M_DATA_W-1:0]  m_tdata   // status[2:0], woken_valid[3],
	                                                // woken_thread[11:4], holder[19:12],
	                                                // held[20], zero pad
);

	mwf_pkg::ctl_t                ctl;
	logic [mwf_pkg::STATUS_W-1:0] status;
	logic                         woken_valid;
	logic [mwf_pkg::TID_W-1:0]    woken_thread;
	logic [mwf_pkg::TID_W-1:0]    holder;
	logic                         held;

	// Sequence each item: accept, read the head waiter, execute
	mwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.ctl      (ctl)
	);

	// Mutex state, waiter queue and result register
	mwf_dp #(
		.MAX_WAITERS    (MAX_WAITERS),
		.THREAD_ID_BITS (THREAD_ID_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cmd          (s_tdata[1:0]),
		.requester    (s_tdata[9:2]),
		.status       (status),
		.woken_valid  (woken_valid),
		.woken_thread (woken_thread),
		.holder       (holder),
		.held         (held)
	);

	// Pack the result item, zero pad to whole bytes
	assign m_tdata = {3'b000, held, holder, woken_thread, woken_valid, status};

	// A released mutex reports no holder
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[20] |-> m_tdata[19:12] == 8'd0)
		else $error("holder nonzero while mutex free");

	// A woken waiter only comes with a hand-off
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2:0] == mwf_pkg::ST_HANDED_OFF && m_tdata[20])
		else $error("woken waiter without hand-off");

	// One item at a time: no new request right after one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	// Never execute while a request may still be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |-> !s_tready && !ctl.load_req)
		else $error("execute overlaps request capture");

endmodule

/* sv/mwf_ctrl.sv */
module mwf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          m_tready,
	output logic          s_tready,
	output logic          m_tvalid,
	output mwf_pkg::ctl_t ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free     = !out_valid_q || m_tready;
	assign s_tready     = (state_q == S_IDLE);
	assign m_tvalid     = out_valid_q;
	assign ctl.load_req = s_tready && s_tvalid;
	assign ctl.exec     = (state_q == S_EXEC) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				// hold until the result register can take the new item
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.exec) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

/* sv/mwf_dp.sv */
module mwf_dp #(
	parameter int MAX_WAITERS    = mwf_pkg::DEF_MAX_WAITERS,
	parameter int THREAD_ID_BITS = mwf_pkg::DEF_THREAD_ID_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mwf_pkg::ctl_t                 ctl,
	input  logic [mwf_pkg::CMD_W-1:0]     cmd,
	input  logic [mwf_pkg::REQ_W-1:0]     requester,
	output logic [mwf_pkg::STATUS_W-1:0]  status,
	output logic                          woken_valid,
	output logic [mwf_pkg::TID_W-1:0]     woken_thread,
	output logic [mwf_pkg::TID_W-1:0]     holder,
	output logic                          held
);

	localparam int AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int CW = $clog2(MAX_WAITERS + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WAITERS - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_WAITERS);

	logic [THREAD_ID_BITS-1:0] mem [MAX_WAITERS];
	logic [THREAD_ID_BITS-1:0] rd_q;

	logic [mwf_pkg::CMD_W-1:0] cmd_q;
	logic [THREAD_ID_BITS-1:0] who_q;
	logic                      locked_q;
	logic [THREAD_ID_BITS-1:0] owner_q;
	logic [AW-1:0]             head_q;
	logic [AW-1:0]             tail_q;
	logic [CW-1:0]             count_q;

	logic [mwf_pkg::STATUS_W-1:0] st_d;
	logic                         locked_d;
	logic [THREAD_ID_BITS-1:0]    owner_d;
	logic                         push;
	logic                         pop;
	logic [AW-1:0]                head_nx;
	logic [AW-1:0]                tail_nx;

	assign head_nx = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
	assign tail_nx = (tail_q == LAST_SLOT) ? '0 : tail_q + AW'(1);

	always_comb begin
		st_d     = mwf_pkg::ST_BUSY;
		locked_d = locked_q;
		owner_d  = owner_q;
		push     = 1'b0;
		pop      = 1'b0;
		case (cmd_q)
			mwf_pkg::CMD_LOCK: begin
				if (!locked_q) begin
					locked_d = 1'b1;
					owner_d  = who_q;
					st_d     = mwf_pkg::ST_GRANTED;
				end else if (count_q != FULL_CNT) begin
					push = 1'b1;
					st_d = mwf_pkg::ST_QUEUED;
				end else begin
					st_d = mwf_pkg::ST_QUEUE_FULL;
				end
			end
			mwf_pkg::CMD_TRY_LOCK: begin
				if (!locked_q) begin
					locked_d = 1'b1;
					owner_d  = who_q;
					st_d     = mwf_pkg::ST_GRANTED;
				end
			end
			mwf_pkg::CMD_UNLOCK: begin
				if (!locked_q || owner_q != who_q) begin
					st_d = mwf_pkg::ST_NOT_OWNER;
				end else if (count_q != '0) begin
					// hand the mutex straight to the oldest waiter
					pop     = 1'b1;
					owner_d = rd_q;
					st_d    = mwf_pkg::ST_HANDED_OFF;
				end else begin
					locked_d = 1'b0;
					owner_d  = '0;
					st_d     = mwf_pkg::ST_RELEASED;
				end
			end
			default: begin
				st_d = mwf_pkg::ST_BUSY;
			end
		endcase
	end

	// Queue storage: write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (ctl.exec && push) mem[tail_q] <= who_q;
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			cmd_q <= cmd;
			who_q <= THREAD_ID_BITS'(requester);
		end
		if (ctl.exec) begin
			status       <= st_d;
			woken_valid  <= pop;
			woken_thread <= pop ? mwf_pkg::TID_W'(rd_q) : '0;
			holder       <= locked_d ? mwf_pkg::TID_W'(owner_d) : '0;
			held         <= locked_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q <= 1'b0;
			owner_q  <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
		end else if (ctl.exec) begin
			locked_q <= locked_d;
			owner_q  <= owner_d;
			if (push) begin
				tail_q  <= tail_nx;
				count_q <= count_q + CW'(1);
			end
			if (pop) begin
				head_q  <= head_nx;
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* verif/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The command field is two bits wide, so the one spare code must be tried too
	localparam logic [mwf_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;
	localparam int MAX_WAITERS = mwf_pkg::DEF_MAX_WAITERS;
	localparam int WQ_AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam logic [WQ_AW-1:0] WAITER_LAST = WQ_AW'(MAX_WAITERS - 1);
	// Limit set far above what the slowest run needs
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;

	// One result item; status sits in the low bits as on m_tdata
	typedef struct packed {
		logic                         held;
		logic [mwf_pkg::TID_W-1:0]    holder;
		logic [mwf_pkg::TID_W-1:0]    woken_thread;
		logic                         woken_valid;
		logic [mwf_pkg::STATUS_W-1:0] status;
	} mutex_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [mwf_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [mwf_pkg::M_DATA_W-1:0] m_tdata;

	// Mirror of the mutex: owner, lock flag and the circular waiter list
	logic                      mtx_locked = 1'b0;
	logic [mwf_pkg::REQ_W-1:0] mtx_owner = '0;
	logic [mwf_pkg::REQ_W-1:0] waiters [MAX_WAITERS];
	logic [WQ_AW-1:0]          waiter_head = '0;
	logic [WQ_AW-1:0]          waiter_tail = '0;
	int unsigned               waiter_count = 0;

	mutex_result_t pending_results[$];

	int unsigned sender_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_until = 0;
	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	int unsigned results_checked = 0;
	int unsigned handoff_count = 0;
	int unsigned full_count = 0;
	int unsigned deepest_queue = 0;

	mutex_with_fifo_waiters_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Count cycles and kill a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, pending_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: hold ready low through a requested stall, else idle at random
	always @(posedge clk) begin
		if (cycle_count < hold_until)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH result %0d at cycle %0d: %s", results_checked, cycle_count, msg);
		error_count++;
	endtask

	// Apply one request to the mirror and return the result it must produce
	function automatic mutex_result_t apply_request(input logic [mwf_pkg::CMD_W-1:0] cmd,
		input logic [mwf_pkg::REQ_W-1:0] who);
		mutex_result_t res;
		res = '0;
		res.status = mwf_pkg::ST_BUSY;
		case (cmd)
			mwf_pkg::CMD_LOCK: begin
				if (!mtx_locked) begin
					mtx_locked = 1'b1;
					mtx_owner = who;
					res.status = mwf_pkg::ST_GRANTED;
				end else if (waiter_count < MAX_WAITERS) begin
					waiters[waiter_tail] = who;
					waiter_tail = (waiter_tail == WAITER_LAST) ? '0 : waiter_tail + 1'b1;
					waiter_count++;
					if (waiter_count > deepest_queue)
						deepest_queue = waiter_count;
					res.status = mwf_pkg::ST_QUEUED;
				end else begin
					res.status = mwf_pkg::ST_QUEUE_FULL;
				end
			end
			mwf_pkg::CMD_TRY_LOCK: begin
				if (!mtx_locked) begin
					mtx_locked = 1'b1;
					mtx_owner = who;
					res.status = mwf_pkg::ST_GRANTED;
				end
			end
			mwf_pkg::CMD_UNLOCK: begin
				if (!mtx_locked || mtx_owner != who) begin
					res.status = mwf_pkg::ST_NOT_OWNER;
				end else if (waiter_count != 0) begin
					// direct hand-off to the oldest waiter
					mtx_owner = waiters[waiter_head];
					waiter_head = (waiter_head == WAITER_LAST) ? '0 : waiter_head + 1'b1;
					waiter_count--;
					res.woken_valid = 1'b1;
					res.woken_thread = mtx_owner;
					res.status = mwf_pkg::ST_HANDED_OFF;
				end else begin
					mtx_locked = 1'b0;
					mtx_owner = '0;
					res.status = mwf_pkg::ST_RELEASED;
				end
			end
			default: ;
		endcase
		res.held = mtx_locked;
		res.holder = mtx_locked ? mtx_owner : '0;
		return res;
	endfunction

	// Offer one request, idling first at random; predict once it is taken
	task automatic send_request(input logic [mwf_pkg::CMD_W-1:0] cmd,
		input logic [mwf_pkg::REQ_W-1:0] who);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {{(mwf_pkg::S_DATA_W - mwf_pkg::CMD_W - mwf_pkg::REQ_W){1'b0}}, who, cmd};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(apply_request(cmd, who));
		items_sent++;
	endtask

	// Pull valid down and wait until every predicted result has come back
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Half the time one of four ids so they collide, else any id
	function automatic logic [mwf_pkg::REQ_W-1:0] pick_thread();
		if ($urandom_range(1) == 0)
			return mwf_pkg::REQ_W'($urandom_range(3));
		return mwf_pkg::REQ_W'($urandom_range(255));
	endfunction

	// Check each accepted result against the oldest prediction
	always @(posedge clk) begin
		mutex_result_t got;
		mutex_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(mutex_result_t)-1:0];
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result 0x%0h with nothing pending", m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (got.status != want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						got.status, want.status));
				if (got.woken_valid != want.woken_valid)
					report_mismatch($sformatf("woken_valid %0d, expected %0d",
						got.woken_valid, want.woken_valid));
				if (got.woken_thread != want.woken_thread)
					report_mismatch($sformatf("woken_thread %0d, expected %0d",
						got.woken_thread, want.woken_thread));
				if (got.holder != want.holder)
					report_mismatch($sformatf("holder %0d, expected %0d",
						got.holder, want.holder));
				if (got.held != want.held)
					report_mismatch($sformatf("held %0d, expected %0d",
						got.held, want.held));
				if (want.status == mwf_pkg::ST_HANDED_OFF)
					handoff_count++;
				if (want.status == mwf_pkg::ST_QUEUE_FULL)
					full_count++;
			end
			results_checked++;
		end
	end

	// Walk the special cases: unlock while free, unlock by another thread,
	// self-lock by the owner, the spare command, try-lock on a held mutex
	task automatic test_directed();
		send_request(mwf_pkg::CMD_UNLOCK, 8'd0);
		send_request(CMD_RESERVED, 8'd255);
		send_request(mwf_pkg::CMD_TRY_LOCK, 8'd255);
		send_request(mwf_pkg::CMD_TRY_LOCK, 8'd0);
		send_request(mwf_pkg::CMD_UNLOCK, 8'd0);
		send_request(mwf_pkg::CMD_LOCK, 8'd255);
		send_request(mwf_pkg::CMD_LOCK, 8'd0);
		send_request(CMD_RESERVED, 8'd0);
		send_request(mwf_pkg::CMD_UNLOCK, 8'd255);
		send_request(mwf_pkg::CMD_UNLOCK, 8'd255);
		send_request(mwf_pkg::CMD_UNLOCK, 8'd0);
		send_request(mwf_pkg::CMD_LOCK, 8'h5a);
		send_request(mwf_pkg::CMD_UNLOCK, 8'h5a);
		send_request(mwf_pkg::CMD_UNLOCK, 8'h5a);
	endtask

	// Fill the waiter list past its depth, then hand the mutex down the line
	task automatic test_queue_full();
		send_request(mwf_pkg::CMD_LOCK, pick_thread());
		repeat (MAX_WAITERS + 1)
			send_request(mwf_pkg::CMD_LOCK, mwf_pkg::REQ_W'($urandom_range(255)));
		send_request(mwf_pkg::CMD_TRY_LOCK, pick_thread());
		while (mtx_locked)
			send_request(mwf_pkg::CMD_UNLOCK, mtx_owner);
	endtask

	// Mostly well-formed traffic: unlocks by the real owner, locks that
	// pile up or drain according to a bias that shifts every few dozen items
	task automatic send_random_mix(input int unsigned n_items);
		int unsigned lock_bias;
		int unsigned pick;
		logic [mwf_pkg::CMD_W-1:0] cmd;
		logic [mwf_pkg::REQ_W-1:0] who;
		lock_bias = 50;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (i % 40 == 0)
				lock_bias = $urandom_range(25, 80);
			pick = $urandom_range(99);
			if (pick < 8) begin
				cmd = mwf_pkg::CMD_W'($urandom_range(3));
				who = mwf_pkg::REQ_W'($urandom_range(255));
			end else if (mtx_locked && $urandom_range(99) >= lock_bias) begin
				cmd = mwf_pkg::CMD_UNLOCK;
				who = ($urandom_range(9) == 0) ? pick_thread() : mtx_owner;
			end else begin
				cmd = ($urandom_range(9) == 0) ? mwf_pkg::CMD_TRY_LOCK : mwf_pkg::CMD_LOCK;
				who = pick_thread();
			end
			send_request(cmd, who);
		end
	endtask

	// Stall the result side for a long stretch while requests keep coming,
	// then pause the sender until everything has drained and send 20 more
	task automatic test_backpressure();
		hold_until <= cycle_count + 250;
		send_random_mix(30);
		wait_for_drain();
		send_random_mix(20);
	endtask

	task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
		input int unsigned n_items);
		sender_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
		send_random_mix(n_items);
	endtask

	initial begin
		// Hold reset low, then release it before the first request
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 23;
		recv_idle_pct <= 81;
		test_directed();
		test_queue_full();
		test_random_phase(23, 81, 440);
		test_random_phase(81, 23, 440);
		test_backpressure();
		test_random_phase(0, 0, 440);

		// Drain, then give the block time to show any stray result
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests, checked %0d results over %0d cycles.",
			items_sent, results_checked, cycle_count);
		$display("Saw %0d hand-offs, %0d full-queue refusals, waiter depth up to %0d.",
			handoff_count, full_count, deepest_queue);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
